FILE: src/cpc_pkg.sv
// Package for the closed polygon curvature block: widths, codes and control types.
package cpc_pkg;

  // Field widths
  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 16;

  // Derived datapath widths
  localparam int MAG_W    = COORD_W;            // |coordinate difference|
  localparam int SQ_W     = 2 * MAG_W + 1;      // squared edge length
  localparam int CR_W     = 2 * MAG_W + 2;      // signed cross product
  localparam int P3_W     = 3 * SQ_W;           // product of three squared lengths
  localparam int RAD_W    = P3_W + (P3_W % 2);  // radicand, even width
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int NUM_W    = SQ_W + 2 * FRAC_BITS + 1;
  localparam int DSH_W    = ROOT_W + COORD_W - 1;
  localparam int CMP_W    = (DSH_W > NUM_W) ? DSH_W : NUM_W;
  localparam int NPROD    = 8;
  localparam int PSEL_W   = 3;
  localparam int STEP_MAX = (SQ_W > ROOT_W) ? SQ_W : ROOT_W;
  localparam int CNT_W    = $clog2(STEP_MAX + 1);

  // Small product slots
  localparam logic [PSEL_W-1:0] PS_BAX = 3'd0;
  localparam logic [PSEL_W-1:0] PS_BAY = 3'd1;
  localparam logic [PSEL_W-1:0] PS_BCX = 3'd2;
  localparam logic [PSEL_W-1:0] PS_BCY = 3'd3;
  localparam logic [PSEL_W-1:0] PS_CAX = 3'd4;
  localparam logic [PSEL_W-1:0] PS_CAY = 3'd5;
  localparam logic [PSEL_W-1:0] PS_CR1 = 3'd6;
  localparam logic [PSEL_W-1:0] PS_CR2 = 3'd7;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_ZERO_LEN  = 2'd1,
    ERR_FEW_NODES = 2'd2
  } err_e;

  // Which result of the current item is being produced
  typedef enum logic [2:0] {
    JOB_MID,    // node before the newest one
    JOB_WRAP,   // newest (final) node
    JOB_CLOSE,  // node 0
    JOB_DEG1,   // two-node polygon, node 1
    JOB_DEG0    // short polygon, node 0
  } job_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD,
    OP_DIFF,
    OP_PROD,
    OP_SUMS,
    OP_MUL1_INIT,
    OP_MUL_STEP,
    OP_MUL2_INIT,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_CHECK,
    OP_DIV_STEP,
    OP_EMIT
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD,
    ST_DIFF,
    ST_PROD,
    ST_SUMS,
    ST_CHECK,
    ST_M1I,
    ST_M1,
    ST_M2I,
    ST_M2,
    ST_SQI,
    ST_SQ,
    ST_DVI,
    ST_DVC,
    ST_DV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e               op;
    job_e              job;
    logic [PSEL_W-1:0] psel;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] item_c;
    logic             item_last;
    logic             zero_len;
    logic             out_busy;
  } status_t;

endpackage

FILE: src/cpc_in_if.sv
// Input channel: one polygon node per transaction.
interface cpc_in_if;
  logic                          valid;
  logic                          ready;
  logic [cpc_pkg::COORD_W-1:0]   point_x;
  logic [cpc_pkg::COORD_W-1:0]   point_y;
  logic                          last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

FILE: src/cpc_out_if.sv
// Output channel: one curvature result per transaction.
interface cpc_out_if;
  logic                        valid;
  logic                        ready;
  logic [cpc_pkg::IDX_W-1:0]   node_index;
  logic [cpc_pkg::COORD_W-1:0] curvature;
  logic [1:0]                  error_code;
  logic                        last_result;

  modport source (output valid, node_index, curvature, error_code, last_result, input ready);
  modport sink   (input valid, node_index, curvature, error_code, last_result, output ready);
endinterface

FILE: src/cpc_ctrl.sv
// Controller state machine: sequences node intake and the iterative curvature steps.
module cpc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cpc_pkg::status_t status_i,
  output cpc_pkg::cmd_t    cmd_o
);

  cpc_pkg::state_e             state_q, state_d;
  cpc_pkg::job_e               job_q, job_d;
  logic [cpc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                        step_done;

  // Last iteration of the counting states
  always_comb begin
    case (state_q)
      cpc_pkg::ST_PROD: step_done = (cnt_q == cpc_pkg::CNT_W'(cpc_pkg::NPROD - 1));
      cpc_pkg::ST_M1,
      cpc_pkg::ST_M2:   step_done = (cnt_q == cpc_pkg::CNT_W'(cpc_pkg::SQ_W - 1));
      cpc_pkg::ST_SQ:   step_done = (cnt_q == cpc_pkg::CNT_W'(cpc_pkg::ROOT_W - 1));
      cpc_pkg::ST_DV:   step_done = (cnt_q == cpc_pkg::CNT_W'(cpc_pkg::COORD_W - 2));
      default:          step_done = 1'b1;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    case (state_q)
      cpc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = cpc_pkg::ST_DISPATCH;
      end
      cpc_pkg::ST_DISPATCH: begin
        if (status_i.item_c == '0) begin
          if (status_i.item_last) begin
            job_d   = cpc_pkg::JOB_DEG0;
            state_d = cpc_pkg::ST_EMIT;
          end else begin
            state_d = cpc_pkg::ST_IDLE;
          end
        end else if (status_i.item_c == cpc_pkg::IDX_W'(1)) begin
          if (status_i.item_last) begin
            job_d   = cpc_pkg::JOB_DEG1;
            state_d = cpc_pkg::ST_EMIT;
          end else begin
            state_d = cpc_pkg::ST_IDLE;
          end
        end else begin
          job_d   = cpc_pkg::JOB_MID;
          state_d = cpc_pkg::ST_LOAD;
        end
      end
      cpc_pkg::ST_LOAD:  state_d = cpc_pkg::ST_DIFF;
      cpc_pkg::ST_DIFF:  state_d = cpc_pkg::ST_PROD;
      cpc_pkg::ST_PROD:  if (step_done) state_d = cpc_pkg::ST_SUMS;
      cpc_pkg::ST_SUMS:  state_d = cpc_pkg::ST_CHECK;
      cpc_pkg::ST_CHECK: begin
        state_d = status_i.zero_len ? cpc_pkg::ST_EMIT : cpc_pkg::ST_M1I;
      end
      cpc_pkg::ST_M1I:   state_d = cpc_pkg::ST_M1;
      cpc_pkg::ST_M1:    if (step_done) state_d = cpc_pkg::ST_M2I;
      cpc_pkg::ST_M2I:   state_d = cpc_pkg::ST_M2;
      cpc_pkg::ST_M2:    if (step_done) state_d = cpc_pkg::ST_SQI;
      cpc_pkg::ST_SQI:   state_d = cpc_pkg::ST_SQ;
      cpc_pkg::ST_SQ:    if (step_done) state_d = cpc_pkg::ST_DVI;
      cpc_pkg::ST_DVI:   state_d = cpc_pkg::ST_DVC;
      cpc_pkg::ST_DVC:   state_d = cpc_pkg::ST_DV;
      cpc_pkg::ST_DV:    if (step_done) state_d = cpc_pkg::ST_EMIT;
      cpc_pkg::ST_EMIT: begin
        if (!status_i.out_busy) begin
          case (job_q)
            cpc_pkg::JOB_MID: begin
              if (status_i.item_last) begin
                job_d   = cpc_pkg::JOB_WRAP;
                state_d = cpc_pkg::ST_LOAD;
              end else begin
                state_d = cpc_pkg::ST_IDLE;
              end
            end
            cpc_pkg::JOB_WRAP: begin
              job_d   = cpc_pkg::JOB_CLOSE;
              state_d = cpc_pkg::ST_LOAD;
            end
            cpc_pkg::JOB_DEG1: begin
              job_d   = cpc_pkg::JOB_DEG0;
              state_d = cpc_pkg::ST_EMIT;
            end
            default: state_d = cpc_pkg::ST_IDLE;
          endcase
        end
      end
      default: state_d = cpc_pkg::ST_IDLE;
    endcase
  end

  // Step counter restarts on every state change
  always_comb begin
    if (state_d != state_q) cnt_d = '0;
    else                    cnt_d = cnt_q + cpc_pkg::CNT_W'(1);
  end

  // Outputs
  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.op    = cpc_pkg::OP_NONE;
    cmd_o.job   = job_q;
    cmd_o.psel  = cnt_q[cpc_pkg::PSEL_W-1:0];
    case (state_q)
      cpc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = cpc_pkg::OP_ACCEPT;
      end
      cpc_pkg::ST_LOAD: cmd_o.op = cpc_pkg::OP_LOAD;
      cpc_pkg::ST_DIFF: cmd_o.op = cpc_pkg::OP_DIFF;
      cpc_pkg::ST_PROD: cmd_o.op = cpc_pkg::OP_PROD;
      cpc_pkg::ST_SUMS: cmd_o.op = cpc_pkg::OP_SUMS;
      cpc_pkg::ST_M1I:  cmd_o.op = cpc_pkg::OP_MUL1_INIT;
      cpc_pkg::ST_M1,
      cpc_pkg::ST_M2:   cmd_o.op = cpc_pkg::OP_MUL_STEP;
      cpc_pkg::ST_M2I:  cmd_o.op = cpc_pkg::OP_MUL2_INIT;
      cpc_pkg::ST_SQI:  cmd_o.op = cpc_pkg::OP_SQRT_INIT;
      cpc_pkg::ST_SQ:   cmd_o.op = cpc_pkg::OP_SQRT_STEP;
      cpc_pkg::ST_DVI:  cmd_o.op = cpc_pkg::OP_DIV_INIT;
      cpc_pkg::ST_DVC:  cmd_o.op = cpc_pkg::OP_DIV_CHECK;
      cpc_pkg::ST_DV:   cmd_o.op = cpc_pkg::OP_DIV_STEP;
      cpc_pkg::ST_EMIT: if (!status_i.out_busy) cmd_o.op = cpc_pkg::OP_EMIT;
      default:          cmd_o.op = cpc_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpc_pkg::ST_IDLE;
      job_q   <= cpc_pkg::JOB_MID;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: src/cpc_datapath.sv
// Datapath: node history, squared lengths, serial multiplier, square root, divider.
module cpc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cpc_pkg::cmd_t                 cmd_i,
  output cpc_pkg::status_t              status_o,
  input  logic [cpc_pkg::COORD_W-1:0]   point_x_i,
  input  logic [cpc_pkg::COORD_W-1:0]   point_y_i,
  input  logic                          last_point_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [cpc_pkg::IDX_W-1:0]     node_index_o,
  output logic [cpc_pkg::COORD_W-1:0]   curvature_o,
  output logic [1:0]                    error_code_o,
  output logic                          last_result_o
);

  localparam int W = cpc_pkg::COORD_W;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

  // Polygon state
  logic [W-1:0]                 first_x_q, first_y_q, second_x_q, second_y_q;
  logic [W-1:0]                 hist_x_q [3];
  logic [W-1:0]                 hist_y_q [3];
  logic [cpc_pkg::IDX_W-1:0]    count_q, item_c_q;
  logic                         item_last_q;
  logic                         out_valid_q;

  // Per-result working registers
  logic [W-1:0]                 ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic [cpc_pkg::MAG_W-1:0]    mag_q [6];
  logic                         neg_q [6];
  logic [2*cpc_pkg::MAG_W-1:0]  prod_q [cpc_pkg::NPROD];
  logic [cpc_pkg::SQ_W-1:0]     s1_q, s2_q, s3_q, mg_q;
  logic                         cr_neg_q, zero_q;
  logic [cpc_pkg::P3_W-1:0]     mul_m_q, acc_q;
  logic [cpc_pkg::SQ_W-1:0]     mul_r_q;
  logic [cpc_pkg::RAD_W-1:0]    rad_q;
  logic [cpc_pkg::ROOT_W-1:0]   root_q;
  logic [cpc_pkg::REM_W-1:0]    rem_q;
  logic [cpc_pkg::NUM_W-1:0]    num_q;
  logic [cpc_pkg::DSH_W-1:0]    dsh_q;
  logic [W-1:0]                 quo_q;
  logic                         sat_q;

  // Result register
  logic [cpc_pkg::IDX_W-1:0]    idx_q;
  logic [W-1:0]                 curv_q;
  logic [1:0]                   err_q;
  logic                         lastr_q;

  // Edge vectors ba, bc, ca, signed one bit wider
  logic [W:0] dif [6];
  assign dif[0] = {ax_q[W-1], ax_q} - {bx_q[W-1], bx_q};
  assign dif[1] = {ay_q[W-1], ay_q} - {by_q[W-1], by_q};
  assign dif[2] = {cx_q[W-1], cx_q} - {bx_q[W-1], bx_q};
  assign dif[3] = {cy_q[W-1], cy_q} - {by_q[W-1], by_q};
  assign dif[4] = {cx_q[W-1], cx_q} - {ax_q[W-1], ax_q};
  assign dif[5] = {cy_q[W-1], cy_q} - {ay_q[W-1], ay_q};

  // Shared small multiplier operands (indices: 0 bax,1 bay,2 bcx,3 bcy,4 cax,5 cay)
  logic [cpc_pkg::MAG_W-1:0]    mop_a, mop_b;
  always_comb begin
    case (cmd_i.psel)
      cpc_pkg::PS_BAX: begin mop_a = mag_q[0]; mop_b = mag_q[0]; end
      cpc_pkg::PS_BAY: begin mop_a = mag_q[1]; mop_b = mag_q[1]; end
      cpc_pkg::PS_BCX: begin mop_a = mag_q[2]; mop_b = mag_q[2]; end
      cpc_pkg::PS_BCY: begin mop_a = mag_q[3]; mop_b = mag_q[3]; end
      cpc_pkg::PS_CAX: begin mop_a = mag_q[4]; mop_b = mag_q[4]; end
      cpc_pkg::PS_CAY: begin mop_a = mag_q[5]; mop_b = mag_q[5]; end
      cpc_pkg::PS_CR1: begin mop_a = mag_q[2]; mop_b = mag_q[1]; end
      default:         begin mop_a = mag_q[3]; mop_b = mag_q[0]; end
    endcase
  end

  // cross(bc, ba) = bcx*bay - bcy*bax
  logic [cpc_pkg::CR_W-1:0] cr_p1, cr_p2, cr_sum;
  logic                     n1, n2;
  assign n1     = neg_q[2] ^ neg_q[1];
  assign n2     = neg_q[3] ^ neg_q[0];
  assign cr_p1  = n1 ? -cpc_pkg::CR_W'(prod_q[6]) : cpc_pkg::CR_W'(prod_q[6]);
  assign cr_p2  = n2 ? -cpc_pkg::CR_W'(prod_q[7]) : cpc_pkg::CR_W'(prod_q[7]);
  assign cr_sum = cr_p1 - cr_p2;

  logic [cpc_pkg::CR_W-1:0] cross_abs;
  logic [cpc_pkg::SQ_W-1:0] s1_d, s2_d, s3_d;
  assign cross_abs = cr_sum[cpc_pkg::CR_W-1] ? -cr_sum : cr_sum;
  assign s1_d = cpc_pkg::SQ_W'(prod_q[0]) + cpc_pkg::SQ_W'(prod_q[1]);
  assign s2_d = cpc_pkg::SQ_W'(prod_q[2]) + cpc_pkg::SQ_W'(prod_q[3]);
  assign s3_d = cpc_pkg::SQ_W'(prod_q[4]) + cpc_pkg::SQ_W'(prod_q[5]);

  // Square root step: bring down two radicand bits
  logic [cpc_pkg::REM_W+1:0] sq_rem2, sq_trial;
  assign sq_rem2  = {rem_q, rad_q[cpc_pkg::RAD_W-1 -: 2]};
  assign sq_trial = (cpc_pkg::REM_W + 2)'({root_q, 2'b01});

  // Divider compare
  logic [cpc_pkg::CMP_W-1:0] dv_rem, dv_den;
  logic                      dv_ge;
  assign dv_rem = cpc_pkg::CMP_W'(num_q);
  assign dv_den = cpc_pkg::CMP_W'(dsh_q);
  assign dv_ge  = (dv_rem >= dv_den);

  // Signed curvature from the quotient magnitude
  logic [W-1:0] kappa;
  assign kappa = cr_neg_q ? -quo_q : (quo_q[W-1] ? MAXV : quo_q);

  // Polygon state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q   <= '0;
      first_y_q   <= '0;
      second_x_q  <= '0;
      second_y_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        hist_x_q[i] <= '0;
        hist_y_q[i] <= '0;
      end
      count_q     <= '0;
      item_c_q    <= '0;
      item_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == cpc_pkg::OP_ACCEPT) begin
        if (count_q == '0) begin
          first_x_q <= point_x_i;
          first_y_q <= point_y_i;
        end
        if (count_q == cpc_pkg::IDX_W'(1)) begin
          second_x_q <= point_x_i;
          second_y_q <= point_y_i;
        end
        hist_x_q[2] <= hist_x_q[1];
        hist_y_q[2] <= hist_y_q[1];
        hist_x_q[1] <= hist_x_q[0];
        hist_y_q[1] <= hist_y_q[0];
        hist_x_q[0] <= point_x_i;
        hist_y_q[0] <= point_y_i;
        item_c_q    <= count_q;
        item_last_q <= last_point_i;
        if (last_point_i)      count_q <= '0;
        else if (~&count_q)    count_q <= count_q + cpc_pkg::IDX_W'(1);
      end
      if (cmd_i.op == cpc_pkg::OP_EMIT) out_valid_q <= 1'b1;
      else if (out_ready_i)             out_valid_q <= 1'b0;
    end
  end

  // Working registers, driven by the controller's command
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cpc_pkg::OP_LOAD: begin
        case (cmd_i.job)
          cpc_pkg::JOB_MID: begin
            ax_q <= hist_x_q[2]; ay_q <= hist_y_q[2];
            bx_q <= hist_x_q[1]; by_q <= hist_y_q[1];
            cx_q <= hist_x_q[0]; cy_q <= hist_y_q[0];
          end
          cpc_pkg::JOB_WRAP: begin
            ax_q <= hist_x_q[1]; ay_q <= hist_y_q[1];
            bx_q <= hist_x_q[0]; by_q <= hist_y_q[0];
            cx_q <= first_x_q;   cy_q <= first_y_q;
          end
          default: begin
            ax_q <= hist_x_q[0]; ay_q <= hist_y_q[0];
            bx_q <= first_x_q;   by_q <= first_y_q;
            cx_q <= second_x_q;  cy_q <= second_y_q;
          end
        endcase
      end
      cpc_pkg::OP_DIFF: begin
        for (int i = 0; i < 6; i++) begin
          neg_q[i] <= dif[i][W];
          mag_q[i] <= dif[i][W] ? cpc_pkg::MAG_W'(-dif[i]) : cpc_pkg::MAG_W'(dif[i]);
        end
      end
      cpc_pkg::OP_PROD: prod_q[cmd_i.psel] <= mop_a * mop_b;
      cpc_pkg::OP_SUMS: begin
        s1_q     <= s1_d;
        s2_q     <= s2_d;
        s3_q     <= s3_d;
        zero_q   <= (s1_d == '0) || (s2_d == '0) || (s3_d == '0);
        mg_q     <= cpc_pkg::SQ_W'(cross_abs);
        cr_neg_q <= cr_sum[cpc_pkg::CR_W-1];
      end
      cpc_pkg::OP_MUL1_INIT: begin
        mul_m_q <= cpc_pkg::P3_W'(s1_q);
        mul_r_q <= s2_q;
        acc_q   <= '0;
      end
      cpc_pkg::OP_MUL2_INIT: begin
        mul_m_q <= acc_q;
        mul_r_q <= s3_q;
        acc_q   <= '0;
      end
      cpc_pkg::OP_MUL_STEP: begin
        if (mul_r_q[0]) acc_q <= acc_q + mul_m_q;
        mul_m_q <= mul_m_q << 1;
        mul_r_q <= mul_r_q >> 1;
      end
      cpc_pkg::OP_SQRT_INIT: begin
        rad_q  <= cpc_pkg::RAD_W'(acc_q);
        rem_q  <= '0;
        root_q <= '0;
      end
      cpc_pkg::OP_SQRT_STEP: begin
        if (sq_rem2 >= sq_trial) begin
          rem_q  <= cpc_pkg::REM_W'(sq_rem2 - sq_trial);
          root_q <= {root_q[cpc_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= cpc_pkg::REM_W'(sq_rem2);
          root_q <= {root_q[cpc_pkg::ROOT_W-2:0], 1'b0};
        end
        rad_q <= rad_q << 2;
      end
      cpc_pkg::OP_DIV_INIT: begin
        num_q <= {mg_q, {(2*cpc_pkg::FRAC_BITS+1){1'b0}}};
        dsh_q <= cpc_pkg::DSH_W'(root_q) << (W - 1);
        quo_q <= '0;
        sat_q <= 1'b0;
      end
      cpc_pkg::OP_DIV_CHECK: begin
        // quotient of 2^(W-1) or more saturates
        if (dv_ge) begin
          sat_q <= 1'b1;
          quo_q <= {1'b1, {(W-1){1'b0}}};
        end
        dsh_q <= dsh_q >> 1;
      end
      cpc_pkg::OP_DIV_STEP: begin
        if (!sat_q) begin
          if (dv_ge) num_q <= cpc_pkg::NUM_W'(dv_rem - dv_den);
          quo_q <= {quo_q[W-2:0], dv_ge};
        end
        dsh_q <= dsh_q >> 1;
      end
      cpc_pkg::OP_EMIT: begin
        case (cmd_i.job)
          cpc_pkg::JOB_MID:  idx_q <= item_c_q - cpc_pkg::IDX_W'(1);
          cpc_pkg::JOB_WRAP: idx_q <= item_c_q;
          cpc_pkg::JOB_DEG1: idx_q <= cpc_pkg::IDX_W'(1);
          default:           idx_q <= '0;
        endcase
        if (cmd_i.job == cpc_pkg::JOB_DEG0 || cmd_i.job == cpc_pkg::JOB_DEG1) begin
          curv_q <= '0;
          err_q  <= cpc_pkg::ERR_FEW_NODES;
        end else if (zero_q) begin
          curv_q <= MAXV;
          err_q  <= cpc_pkg::ERR_ZERO_LEN;
        end else begin
          curv_q <= kappa;
          err_q  <= cpc_pkg::ERR_OK;
        end
        lastr_q <= (cmd_i.job == cpc_pkg::JOB_CLOSE) || (cmd_i.job == cpc_pkg::JOB_DEG0);
      end
      default: ;
    endcase
  end

  assign status_o.item_c    = item_c_q;
  assign status_o.item_last = item_last_q;
  assign status_o.zero_len  = zero_q;
  assign status_o.out_busy  = out_valid_q & ~out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign node_index_o  = idx_q;
  assign curvature_o   = curv_q;
  assign error_code_o  = err_q;
  assign last_result_o = lastr_q;

endmodule

FILE: src/closed_polygon_curvature.sv
// Closed polygon curvature: one node in, curvature of its neighbor (and ring closure) out.
// Each result takes 8 products, two 65-step serial multiplies, a 98-step square root and a
// 31-step divide on the shared serial units; no new node is taken until that node's results are emitted.
// A final node of a polygon of three or more nodes yields three results.
// A new node is taken while the last result still waits in the output register.
// Reset: asynchronous active low; clears node history, node count and output valid.
module closed_polygon_curvature (
  input  logic clk_i,
  input  logic rst_ni,
  cpc_in_if.sink    in_i,
  cpc_out_if.source out_o
);

  cpc_pkg::cmd_t    cmd;
  cpc_pkg::status_t status;

  // Sequencing
  cpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage
  cpc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .point_x_i     (in_i.point_x),
    .point_y_i     (in_i.point_y),
    .last_point_i  (in_i.last_point),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .node_index_o  (out_o.node_index),
    .curvature_o   (out_o.curvature),
    .error_code_o  (out_o.error_code),
    .last_result_o (out_o.last_result)
  );

endmodule

FILE: tb/sv/closed_polygon_curvature_tb.sv
// Testbench for closed_polygon_curvature: directed and random polygons, scoreboard check.
module closed_polygon_curvature_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [255:0] wide_t;
  typedef logic signed [cpc_pkg::COORD_W-1:0] coord_t;

  typedef struct {
    logic [cpc_pkg::IDX_W-1:0]   idx;
    logic [cpc_pkg::COORD_W-1:0] curv;
    cpc_pkg::err_e               err;
    logic                        last;
  } curv_result_t;

  localparam int          CYCLE_LIMIT = 3_000_000;
  localparam int          SETTLE      = 1000;
  localparam logic [cpc_pkg::COORD_W-1:0] KAPPA_MAX = {1'b0, {(cpc_pkg::COORD_W-1){1'b1}}};

  logic clk_i;
  logic rst_ni;

  cpc_in_if  in_if();
  cpc_out_if out_if();

  closed_polygon_curvature uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Predicted ring state
  coord_t                    first_x, first_y, second_x, second_y;
  coord_t                    older_x, older_y, recent_x, recent_y;
  logic [cpc_pkg::IDX_W-1:0] nodes_seen;

  curv_result_t pending_curv[$];
  int  mismatches;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_cycles;
  int  cycle_count;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Squared length of a difference vector
  function automatic wide_t sq_len(input logic signed [63:0] dx, input logic signed [63:0] dy);
    wide_t mx, my;
    mx = wide_t'(dx < 0 ? -dx : dx);
    my = wide_t'(dy < 0 ? -dy : dy);
    return mx * mx + my * my;
  endfunction

  // Three-point curvature at b, exact integer arithmetic
  function automatic void node_curvature(input coord_t ax, ay, bx, by, cx, cy,
                                         output logic [cpc_pkg::COORD_W-1:0] kap,
                                         output cpc_pkg::err_e err);
    logic signed [63:0]  bax, bay, bcx, bcy;
    logic signed [127:0] wbax, wbay, wbcx, wbcy, cr;
    logic [127:0]        mg;
    wide_t s1, s2, s3, prod, root, t, num, q;
    bax = 64'(ax) - 64'(bx);
    bay = 64'(ay) - 64'(by);
    bcx = 64'(cx) - 64'(bx);
    bcy = 64'(cy) - 64'(by);
    s1 = sq_len(bax, bay);
    s2 = sq_len(bcx, bcy);
    s3 = sq_len(64'(cx) - 64'(ax), 64'(cy) - 64'(ay));
    if (s1 == 0 || s2 == 0 || s3 == 0) begin
      kap = KAPPA_MAX;
      err = cpc_pkg::ERR_ZERO_LEN;
      return;
    end
    prod = s1 * s2 * s3;
    root = '0;
    for (int k = 127; k >= 0; k--) begin
      t = root | (wide_t'(1) << k);
      if (t * t <= prod) root = t;
    end
    wbax = bax; wbay = bay; wbcx = bcx; wbcy = bcy;
    cr = wbcx * wbay - wbcy * wbax;
    mg = (cr < 0) ? -cr : cr;
    num = wide_t'(mg) << (2 * cpc_pkg::FRAC_BITS + 1);
    if ((root << (cpc_pkg::COORD_W - 1)) <= num) q = wide_t'(1) << (cpc_pkg::COORD_W - 1);
    else q = num / root;
    if (cr < 0) kap = -q[cpc_pkg::COORD_W-1:0];
    else kap = (q > wide_t'(KAPPA_MAX)) ? KAPPA_MAX : q[cpc_pkg::COORD_W-1:0];
    err = cpc_pkg::ERR_OK;
  endfunction

  function automatic void expect_result(input logic [cpc_pkg::IDX_W-1:0] idx,
                                        input logic [cpc_pkg::COORD_W-1:0] curv,
                                        input cpc_pkg::err_e err, input logic last);
    curv_result_t r;
    r.idx = idx; r.curv = curv; r.err = err; r.last = last;
    pending_curv.push_back(r);
  endfunction

  // Advance the ring state by one node and queue its results
  function automatic void predict_node(input coord_t px, py, input logic last);
    logic [cpc_pkg::COORD_W-1:0] kap;
    cpc_pkg::err_e err;
    if (nodes_seen == 0) begin
      first_x = px; first_y = py;
      if (last) expect_result(0, '0, cpc_pkg::ERR_FEW_NODES, 1'b1);
    end else if (nodes_seen == 1) begin
      second_x = px; second_y = py;
      if (last) begin
        expect_result(1, '0, cpc_pkg::ERR_FEW_NODES, 1'b0);
        expect_result(0, '0, cpc_pkg::ERR_FEW_NODES, 1'b1);
      end
    end else begin
      node_curvature(older_x, older_y, recent_x, recent_y, px, py, kap, err);
      expect_result(nodes_seen - 1'b1, kap, err, 1'b0);
      if (last) begin
        node_curvature(recent_x, recent_y, px, py, first_x, first_y, kap, err);
        expect_result(nodes_seen, kap, err, 1'b0);
        node_curvature(px, py, first_x, first_y, second_x, second_y, kap, err);
        expect_result(0, kap, err, 1'b1);
      end
    end
    older_x = recent_x; older_y = recent_y;
    recent_x = px; recent_y = py;
    if (last) nodes_seen = '0;
    else if (nodes_seen != '1) nodes_seen = nodes_seen + 1'b1;
  endfunction

  // Offer one node, optionally after a random gap; returns at the accepting edge
  task automatic send_node(input coord_t px, py, input logic last);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.point_x    <= px;
    in_if.point_y    <= py;
    in_if.last_point <= last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_node(px, py, last);
  endtask

  // Stop offering and wait until every expected transaction has arrived
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_curv.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic coord_t rand_coord(input int bits);
    coord_t v;
    v = coord_t'($urandom);
    return v >>> (cpc_pkg::COORD_W - bits);
  endfunction

  // One random polygon: mostly well formed, sometimes short or with repeated nodes
  task automatic send_random_polygon(output int sent);
    int     n, scale;
    coord_t cx, cy, px, py;
    n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
    scale = $urandom_range(2, 32);
    cx = rand_coord($urandom_range(1, 32));
    cy = rand_coord($urandom_range(1, 32));
    for (int i = 0; i < n; i++) begin
      if (i == 0 || $urandom_range(9) != 0) begin
        px = cx + rand_coord(scale);
        py = cy + rand_coord(scale);
      end
      send_node(px, py, i == n - 1);
    end
    sent = n;
  endtask

  task automatic run_random(input int items);
    int done, n;
    done = 0;
    while (done < items) begin
      send_random_polygon(n);
      done += n;
    end
    wait_drained();
  endtask

  // Short polygons, plain and degenerate triangles, extreme coordinates
  task automatic test_directed();
    coord_t cmax, cmin;
    cmax = {1'b0, {(cpc_pkg::COORD_W-1){1'b1}}};
    cmin = {1'b1, {(cpc_pkg::COORD_W-1){1'b0}}};
    send_node(32'h0001_0000, 32'h0002_0000, 1'b1);
    send_node(32'h0001_0000, 32'h0002_0000, 1'b0);
    send_node(32'hFFFF_0000, 32'h0000_8000, 1'b1);
    // unit right triangle, both orientations
    send_node(32'h0, 32'h0, 1'b0);
    send_node(32'h0001_0000, 32'h0, 1'b0);
    send_node(32'h0, 32'h0001_0000, 1'b1);
    send_node(32'h0, 32'h0, 1'b0);
    send_node(32'h0, 32'h0001_0000, 1'b0);
    send_node(32'h0001_0000, 32'h0, 1'b1);
    // repeated node gives zero-length edges
    send_node(32'h0003_0000, 32'h0003_0000, 1'b0);
    send_node(32'h0003_0000, 32'h0003_0000, 1'b0);
    send_node(32'h0005_0000, 32'h0001_0000, 1'b1);
    // collinear nodes
    send_node(32'h0, 32'h0, 1'b0);
    send_node(32'h0001_0000, 32'h0001_0000, 1'b0);
    send_node(32'h0002_0000, 32'h0002_0000, 1'b1);
    // tiny four-node polygon saturates positive and negative
    send_node(32'h0, 32'h0, 1'b0);
    send_node(32'h1, 32'h0, 1'b0);
    send_node(32'h0, 32'h1, 1'b0);
    send_node(32'h1, 32'h1, 1'b1);
    // full-range coordinates
    send_node(cmax, cmin, 1'b0);
    send_node(cmin, cmin, 1'b0);
    send_node(cmin, cmax, 1'b0);
    send_node(cmax, cmax, 1'b1);
    wait_drained();
  endtask

  task automatic test_no_idle();
    send_idle_pct = 0; recv_stall_pct = 0;
    run_random(60);
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 50; recv_stall_pct = 0;
    run_random(60);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0; recv_stall_pct = 50;
    run_random(60);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 17; recv_stall_pct = 17;
    run_random(60);
  endtask

  // Long receiver hold-off while nodes keep coming, so the input backs up
  task automatic test_backpressure();
    int n;
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_cycles = 4000;
    repeat (4) send_random_polygon(n);
    wait_drained();
  endtask

  // Receiver ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin
    curv_result_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_curv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: idx=%0d curv=%h err=%0d last=%0b",
                   out_if.node_index, out_if.curvature, out_if.error_code,
                   out_if.last_result);
      end else begin
        e = pending_curv.pop_front();
        if (out_if.node_index !== e.idx || out_if.curvature !== e.curv ||
            out_if.error_code !== e.err || out_if.last_result !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp idx=%0d curv=%h err=%0d last=%0b, ",
                      "got idx=%0d curv=%h err=%0d last=%0b"},
                     e.idx, e.curv, e.err, e.last, out_if.node_index, out_if.curvature,
                     out_if.error_code, out_if.last_result);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    mismatches     = 0;
    cycle_count    = 0;
    hold_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    nodes_seen     = '0;
    first_x = '0; first_y = '0; second_x = '0; second_y = '0;
    older_x = '0; older_y = '0; recent_x = '0; recent_y = '0;
    in_if.valid      <= 1'b0;
    in_if.point_x    <= '0;
    in_if.point_y    <= '0;
    in_if.last_point <= 1'b0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_no_idle();
    test_sender_idle();
    test_backpressure();
    test_receiver_stall();
    test_both_idle();

    if (mismatches == 0 && pending_curv.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: closed_polygon_curvature.f
src/cpc_pkg.sv
src/cpc_in_if.sv
src/cpc_out_if.sv
src/cpc_ctrl.sv
src/cpc_datapath.sv
src/closed_polygon_curvature.sv
tb/sv/closed_polygon_curvature_tb.sv
